// ===== rtl/dbda_pkg.sv =====
package dbda_pkg;

    localparam int COORD_W      = 16;
    localparam int SCORE_W      = 16;
    localparam int LABEL_W      = 8;
    localparam int SCALE_W      = 16;
    localparam int PAD_W        = 12;
    localparam int REGION_W     = 13;
    localparam int COORD_FRAC   = 4;
    localparam int SCALE_FRAC   = 12;
    localparam int MAX_CLASSES  = 256;

    localparam int S_DATA_W     = 80;
    localparam int M_DATA_W     = 88;
    localparam int APB_ADDR_W   = 5;
    localparam int APB_DATA_W   = 32;

    // corner in q.5 before scaling, products and sums
    localparam int CORNER_W     = 19;
    localparam int CORNER_P_W   = CORNER_W + SCALE_W + 1;
    localparam int EXTENT_P_W   = COORD_W + SCALE_W + 1;
    localparam int CORNER_SH    = COORD_FRAC + 1 + SCALE_FRAC;
    localparam int EXTENT_SH    = COORD_FRAC + SCALE_FRAC;

    localparam logic [SCORE_W-1:0] RST_THRESHOLD = 16'd16384;
    localparam logic [SCALE_W-1:0] RST_INV_SCALE = 16'd4096;

    typedef enum logic [2:0] {
        REG_THRESHOLD   = 3'd0,
        REG_INV_SCALE_X = 3'd1,
        REG_INV_SCALE_Y = 3'd2,
        REG_LEFT_PAD    = 3'd3,
        REG_TOP_PAD     = 3'd4,
        REG_REGION_X    = 3'd5,
        REG_REGION_Y    = 3'd6,
        REG_EQUAL_SCALE = 3'd7
    } t_reg_idx;

    localparam logic OP_BOX   = 1'b0;
    localparam logic OP_SCORE = 1'b1;

    function automatic logic [COORD_W-1:0] f_sat_corner(input logic [CORNER_W-1:0] v);
        logic [COORD_W-1:0] res;
        if (v[CORNER_W-1:COORD_W-1] == '0 || v[CORNER_W-1:COORD_W-1] == '1) begin
            res = v[COORD_W-1:0];
        end else if (v[CORNER_W-1]) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

    function automatic logic [COORD_W-1:0] f_sat_extent(input logic [COORD_W:0] v);
        logic [COORD_W-1:0] res;
        if (v[COORD_W] == v[COORD_W-1]) begin
            res = v[COORD_W-1:0];
        end else if (v[COORD_W]) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ===== rtl/detection_box_decode_argmax_core.sv =====
// Per-anchor class argmax and box decode.
// Input stream s_*: one word per cycle while s_tready is high; tuser = 0
// carries a box (center x/y, width, height in Q11.4) and starts a new
// anchor; tuser = 1 carries one class score in Q0.16, with tlast on the
// final class of the anchor. On the final score, if the best score is
// strictly above the threshold, one result word leaves on m_*: label, best
// score and the decoded rectangle in integer pixels, saturated to 16 bits.
// Configuration (threshold, reciprocal scales, pads, region offset,
// equal_scale) is written over the APB port; the user must write it only
// while the block is idle, as the block itself has no check for this.
// Throughput: one input word per cycle while s_tready is high; score
// tracking is updated at accept. A result word passes the four-stage
// decode pipe (corner form, multiply, region add, truncate and saturate
// into the output register) before m_tvalid rises. When m_tready is low
// the pipe stages fill one by one; s_tready falls only when every stage
// holds a result, and nothing is dropped. Reset clears the held box, score
// tracking and pipe, and loads the register defaults.
module detection_box_decode_argmax_core
    import dbda_pkg::*;
#(
    parameter int MaxClasses = MAX_CLASSES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // center_x, center_y, box_width, box_height, class_score
    input  logic [S_DATA_W-1:0]   s_tdata,
    // operation
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // label, best_score, left, top, rect_width, rect_height
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // configuration
    logic [SCORE_W-1:0]  r_thr;
    logic [SCALE_W-1:0]  r_inv_x, r_inv_y;
    logic [PAD_W-1:0]    r_pad_l, r_pad_t;
    logic [REGION_W-1:0] r_reg_x, r_reg_y;
    logic                r_eq;
    t_reg_idx            w_idx;
    logic                w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= RST_THRESHOLD;
            r_inv_x <= RST_INV_SCALE;
            r_inv_y <= RST_INV_SCALE;
            r_pad_l <= '0;
            r_pad_t <= '0;
            r_reg_x <= '0;
            r_reg_y <= '0;
            r_eq    <= 1'b1;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_THRESHOLD:   r_thr   <= pwdata[SCORE_W-1:0];
                REG_INV_SCALE_X: r_inv_x <= pwdata[SCALE_W-1:0];
                REG_INV_SCALE_Y: r_inv_y <= pwdata[SCALE_W-1:0];
                REG_LEFT_PAD:    r_pad_l <= pwdata[PAD_W-1:0];
                REG_TOP_PAD:     r_pad_t <= pwdata[PAD_W-1:0];
                REG_REGION_X:    r_reg_x <= pwdata[REGION_W-1:0];
                REG_REGION_Y:    r_reg_y <= pwdata[REGION_W-1:0];
                REG_EQUAL_SCALE: r_eq    <= pwdata[0];
                default:         r_eq    <= r_eq;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_THRESHOLD:   prdata = APB_DATA_W'(r_thr);
            REG_INV_SCALE_X: prdata = APB_DATA_W'(r_inv_x);
            REG_INV_SCALE_Y: prdata = APB_DATA_W'(r_inv_y);
            REG_LEFT_PAD:    prdata = APB_DATA_W'(r_pad_l);
            REG_TOP_PAD:     prdata = APB_DATA_W'(r_pad_t);
            REG_REGION_X:    prdata = APB_DATA_W'(r_reg_x);
            REG_REGION_Y:    prdata = APB_DATA_W'(r_reg_y);
            REG_EQUAL_SCALE: prdata = APB_DATA_W'(r_eq);
            default:         prdata = '0;
        endcase
    end

    // input fields
    logic [COORD_W-1:0] w_cx, w_cy, w_bw, w_bh;
    logic [SCORE_W-1:0] w_score;

    assign w_cx    = s_tdata[15:0];
    assign w_cy    = s_tdata[31:16];
    assign w_bw    = s_tdata[47:32];
    assign w_bh    = s_tdata[63:48];
    assign w_score = s_tdata[79:64];

    // held box and score tracking
    logic [COORD_W-1:0] r_cx, r_cy, r_bw, r_bh;
    logic [SCORE_W-1:0] r_max;
    logic [LABEL_W-1:0] r_lab, r_cnt;
    logic               r_seen;
    logic               w_take, w_emit, w_acc;
    logic [SCORE_W-1:0] n_max;
    logic [LABEL_W-1:0] n_lab;

    assign w_acc  = s_tvalid & s_tready;
    assign w_take = !r_seen || (w_score > r_max);
    assign n_max  = w_take ? w_score : r_max;
    assign n_lab  = w_take ? r_cnt : r_lab;
    assign w_emit = (s_tuser == OP_SCORE) && s_tlast && (n_max > r_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= '0;
            r_cy   <= '0;
            r_bw   <= '0;
            r_bh   <= '0;
            r_max  <= '0;
            r_lab  <= '0;
            r_cnt  <= '0;
            r_seen <= 1'b0;
        end else if (w_acc) begin
            if (s_tuser == OP_BOX || s_tlast) begin
                r_max  <= '0;
                r_lab  <= '0;
                r_cnt  <= '0;
                r_seen <= 1'b0;
            end else begin
                r_max  <= n_max;
                r_lab  <= n_lab;
                r_seen <= 1'b1;
                if (r_cnt < LABEL_W'(MaxClasses - 1)) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (s_tuser == OP_BOX) begin
                r_cx <= w_cx;
                r_cy <= w_cy;
                r_bw <= w_bw;
                r_bh <= w_bh;
            end
        end
    end

    // corner in q.5: 2*center - size - pad*32, the pad term only with equal_scale
    logic [CORNER_W-1:0] w_qx, w_qy;

    assign w_qx = {{2{r_cx[COORD_W-1]}}, r_cx, 1'b0} - {{3{r_bw[COORD_W-1]}}, r_bw}
                - (r_eq ? {2'b0, r_pad_l, 5'b0} : CORNER_W'(0));
    assign w_qy = {{2{r_cy[COORD_W-1]}}, r_cy, 1'b0} - {{3{r_bh[COORD_W-1]}}, r_bh}
                - (r_eq ? {2'b0, r_pad_t, 5'b0} : CORNER_W'(0));

    // pipe control
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_ld2, w_ld3, w_ld4, w_out;

    assign w_out    = r_v4 & m_tready;
    assign w_ld4    = r_v3 & (!r_v4 | w_out);
    assign w_ld3    = r_v2 & (!r_v3 | w_ld4);
    assign w_ld2    = r_v1 & (!r_v2 | w_ld3);
    assign s_tready = !r_v1 | w_ld2;
    assign m_tvalid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= (w_acc & w_emit) | (r_v1 & !w_ld2);
            r_v2 <= w_ld2 | (r_v2 & !w_ld3);
            r_v3 <= w_ld3 | (r_v3 & !w_ld4);
            r_v4 <= w_ld4 | (r_v4 & !w_out);
        end
    end

    // stage 1: label, score, corners, sizes
    logic [LABEL_W-1:0]         r1_lab;
    logic [SCORE_W-1:0]         r1_score;
    logic signed [CORNER_W-1:0] r1_qx, r1_qy;
    logic signed [COORD_W-1:0]  r1_bw, r1_bh;

    always_ff @(posedge i_clk) begin
        if (w_acc && w_emit && (!r_v1 || w_ld2)) begin
            r1_lab   <= n_lab;
            r1_score <= n_max;
            r1_qx    <= w_qx;
            r1_qy    <= w_qy;
            r1_bw    <= r_bw;
            r1_bh    <= r_bh;
        end
    end

    // stage 2: products
    logic [LABEL_W-1:0]           r2_lab;
    logic [SCORE_W-1:0]           r2_score;
    logic signed [CORNER_P_W-1:0] r2_px, r2_py;
    logic signed [EXTENT_P_W-1:0] r2_pw, r2_ph;
    logic signed [SCALE_W:0]      w_sx, w_sy;

    assign w_sx = {1'b0, r_inv_x};
    assign w_sy = {1'b0, r_inv_y};

    always_ff @(posedge i_clk) begin
        if (w_ld2) begin
            r2_lab   <= r1_lab;
            r2_score <= r1_score;
            r2_px    <= r1_qx * w_sx;
            r2_py    <= r1_qy * w_sy;
            r2_pw    <= r1_bw * w_sx;
            r2_ph    <= r1_bh * w_sy;
        end
    end

    // stage 3: region offset on corners
    logic [LABEL_W-1:0]           r3_lab;
    logic [SCORE_W-1:0]           r3_score;
    logic signed [CORNER_P_W-1:0] r3_sx, r3_sy;
    logic signed [EXTENT_P_W-1:0] r3_pw, r3_ph;

    always_ff @(posedge i_clk) begin
        if (w_ld3) begin
            r3_lab   <= r2_lab;
            r3_score <= r2_score;
            r3_sx    <= r2_px + $signed({{(CORNER_P_W-REGION_W-CORNER_SH){1'b0}},
                                         r_reg_x, {CORNER_SH{1'b0}}});
            r3_sy    <= r2_py + $signed({{(CORNER_P_W-REGION_W-CORNER_SH){1'b0}},
                                         r_reg_y, {CORNER_SH{1'b0}}});
            r3_pw    <= r2_pw;
            r3_ph    <= r2_ph;
        end
    end

    // stage 4: truncate toward zero, saturate, output register
    logic [CORNER_P_W-1:0] w_tx, w_ty;
    logic [EXTENT_P_W-1:0] w_tw, w_th;
    logic [M_DATA_W-1:0]   r_out;

    assign w_tx = r3_sx + (r3_sx[CORNER_P_W-1] ? CORNER_P_W'((1 << CORNER_SH) - 1)
                                               : CORNER_P_W'(0));
    assign w_ty = r3_sy + (r3_sy[CORNER_P_W-1] ? CORNER_P_W'((1 << CORNER_SH) - 1)
                                               : CORNER_P_W'(0));
    assign w_tw = r3_pw + (r3_pw[EXTENT_P_W-1] ? EXTENT_P_W'((1 << EXTENT_SH) - 1)
                                               : EXTENT_P_W'(0));
    assign w_th = r3_ph + (r3_ph[EXTENT_P_W-1] ? EXTENT_P_W'((1 << EXTENT_SH) - 1)
                                               : EXTENT_P_W'(0));

    always_ff @(posedge i_clk) begin
        if (w_ld4) begin
            r_out <= {f_sat_extent(w_th[EXTENT_P_W-1:EXTENT_SH]),
                      f_sat_extent(w_tw[EXTENT_P_W-1:EXTENT_SH]),
                      f_sat_corner(w_ty[CORNER_P_W-1:CORNER_SH]),
                      f_sat_corner(w_tx[CORNER_P_W-1:CORNER_SH]),
                      r3_score, r3_lab};
        end
    end

    assign m_tdata = r_out;

endmodule

// ===== rtl/dbda_checker.sv =====
module dbda_checker
    import dbda_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_DATA_W-1:0]   m_tdata,
    input logic                  psel,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  pready
);

    // no result word right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result word valid after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result word changed while stalled");

    // input side never blocks while the output side is free
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_tvalid && $past(!m_tvalid) && $past(!m_tvalid, 2) && $past(!m_tvalid, 3)
        && $past(i_rst_n, 4) |-> s_tready)
        else $error("input stalled with empty pipe");

    a_flag_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && !pwrite && pready && t_reg_idx'(paddr[APB_ADDR_W-1:2]) == REG_EQUAL_SCALE
        |-> prdata[APB_DATA_W-1:1] == '0)
        else $error("equal_scale read has stray bits");

endmodule

bind detection_box_decode_argmax_core dbda_checker u_dbda_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .prdata   (prdata),
    .pready   (pready)
);

// ===== bench/tb_detection_box_decode_argmax_core.sv =====
`timescale 1ns / 100ps

module tb_detection_box_decode_argmax_core;
    import dbda_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_WORDS  = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 12;

    // s_tdata fields, lowest first: center_x, center_y, box_width, box_height, class_score
    typedef struct packed {
        logic [15:0]        class_score;
        logic signed [15:0] box_height;
        logic signed [15:0] box_width;
        logic signed [15:0] center_y;
        logic signed [15:0] center_x;
    } t_anchor_word;

    // m_tdata fields, lowest first: label, best_score, left, top, rect_width, rect_height
    typedef struct packed {
        logic signed [15:0] rect_height;
        logic signed [15:0] rect_width;
        logic signed [15:0] top;
        logic signed [15:0] left;
        logic [15:0]        best_score;
        logic [7:0]         label;
    } t_detection;

    class t_detection_tracker;
        int unsigned threshold, inv_x, inv_y, pad_l, pad_t, reg_x, reg_y, eq_scale;
        int unsigned best, best_label, class_idx;
        bit          scored;
        int          box[4];
        t_detection  pending[$];
        int          errors;

        function new();
            threshold = RST_THRESHOLD;
            inv_x     = RST_INV_SCALE;
            inv_y     = RST_INV_SCALE;
            pad_l     = 0;
            pad_t     = 0;
            reg_x     = 0;
            reg_y     = 0;
            eq_scale  = 1;
            foreach (box[i]) box[i] = 0;
            clear_tracking();
            errors = 0;
        endfunction

        function void clear_tracking();
            best       = 0;
            best_label = 0;
            class_idx  = 0;
            scored     = 0;
        endfunction

        function void set_reg(t_reg_idx idx, int unsigned v);
            case (idx)
                REG_THRESHOLD:   threshold = v & 32'hFFFF;
                REG_INV_SCALE_X: inv_x     = v & 32'hFFFF;
                REG_INV_SCALE_Y: inv_y     = v & 32'hFFFF;
                REG_LEFT_PAD:    pad_l     = v & 32'hFFF;
                REG_TOP_PAD:     pad_t     = v & 32'hFFF;
                REG_REGION_X:    reg_x     = v & 32'h1FFF;
                REG_REGION_Y:    reg_y     = v & 32'h1FFF;
                REG_EQUAL_SCALE: eq_scale  = v & 32'h1;
                default: ;
            endcase
        endfunction

        function logic signed [15:0] sat16(longint v);
            if (v > 32767) return 16'sh7FFF;
            if (v < -32768) return 16'sh8000;
            return 16'(v);
        endfunction

        // corner in q.5, scaled to q.17, region added, truncated toward zero
        function logic signed [15:0] corner_px(int c, int s, int unsigned pad,
                                               int unsigned inv, int unsigned region);
            longint q5;
            longint den;
            q5  = 2 * longint'(c) - longint'(s);
            den = longint'(1) << (COORD_FRAC + 1 + SCALE_FRAC);
            if (eq_scale != 0) q5 -= longint'(pad) * 32;
            return sat16((q5 * longint'(inv) + longint'(region) * den) / den);
        endfunction

        function logic signed [15:0] extent_px(int s, int unsigned inv);
            longint den;
            den = longint'(1) << (COORD_FRAC + SCALE_FRAC);
            return sat16((longint'(s) * longint'(inv)) / den);
        endfunction

        function void take_word(logic op, t_anchor_word d, logic last);
            t_detection det;
            if (op == OP_BOX) begin
                box[0] = d.center_x;
                box[1] = d.center_y;
                box[2] = d.box_width;
                box[3] = d.box_height;
                clear_tracking();
                return;
            end
            if (!scored || d.class_score > best) begin
                best       = d.class_score;
                best_label = class_idx;
            end
            scored = 1;
            if (class_idx < MAX_CLASSES - 1) class_idx++;
            if (last) begin
                if (best > threshold) begin
                    det.label       = 8'(best_label);
                    det.best_score  = 16'(best);
                    det.left        = corner_px(box[0], box[2], pad_l, inv_x, reg_x);
                    det.top         = corner_px(box[1], box[3], pad_t, inv_y, reg_y);
                    det.rect_width  = extent_px(box[2], inv_x);
                    det.rect_height = extent_px(box[3], inv_y);
                    pending = {pending, det};
                end
                clear_tracking();
            end
        endfunction

        function void cmp_field(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void match_detection(t_detection got);
            t_detection exp_d;
            if (pending.size() == 0) begin
                $error("unexpected detection word %h", got);
                errors++;
                return;
            end
            exp_d = pending.pop_front();
            cmp_field("label", exp_d.label, got.label);
            cmp_field("best_score", exp_d.best_score, got.best_score);
            cmp_field("left", exp_d.left, got.left);
            cmp_field("top", exp_d.top, got.top);
            cmp_field("rect_width", exp_d.rect_width, got.rect_width);
            cmp_field("rect_height", exp_d.rect_height, got.rect_height);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    t_detection_tracker tracker;
    bit                 calm_run;
    bit                 hold_req;
    int                 words_sent;
    int                 cycle_count;

    detection_box_decode_argmax_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) tracker.match_detection(t_detection'(m_tdata));
    end

    // receiver: random backpressure, calm stretches and one long hold-off
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (calm_run) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 18);
            end
        end
    end

    task automatic send_word(logic op, t_anchor_word d, logic last);
        while (!calm_run && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= op;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        tracker.take_word(op, d, last);
        words_sent++;
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(2))
            0: return 16'($urandom);
            1: return 16'($urandom_range(2000)) - 16'd1000;
            default: return 16'($urandom_range(16000)) - 16'd8000;
        endcase
    endfunction

    function automatic t_anchor_word box_word(logic [15:0] cx, logic [15:0] cy,
                                              logic [15:0] w, logic [15:0] h);
        t_anchor_word d;
        d.center_x    = cx;
        d.center_y    = cy;
        d.box_width   = w;
        d.box_height  = h;
        d.class_score = 16'($urandom);
        return d;
    endfunction

    function automatic t_anchor_word score_word(logic [15:0] s);
        t_anchor_word d;
        d             = t_anchor_word'(S_DATA_W'({$urandom, $urandom, $urandom}));
        d.class_score = s;
        return d;
    endfunction

    function automatic logic [15:0] pick_score(logic [15:0] prev);
        int t;
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return prev;
            2: begin
                t = int'(tracker.threshold) + int'($urandom_range(4)) - 2;
                if (t < 0) t = 0;
                if (t > 65535) t = 65535;
                return 16'(t);
            end
            default: return 16'($urandom_range(65535, 40000));
        endcase
    endfunction

    task automatic random_anchor(int n_cls, bit ramp);
        logic [15:0] s;
        s = 16'($urandom);
        send_word(OP_BOX, box_word(rand_coord(), rand_coord(), rand_coord(), rand_coord()),
                  1'($urandom));
        for (int i = 0; i < n_cls; i++) begin
            s = ramp ? 16'(i * 200) : pick_score(s);
            send_word(OP_SCORE, score_word(s), i == n_cls - 1);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(input int unsigned vals[8]);
        for (int i = 0; i < 8; i++) write_reg(t_reg_idx'(i), vals[i]);
    endtask

    initial begin
        int unsigned cfg[8];
        int          phase_end;

        tracker    = new();
        calm_run   = 1'b0;
        hold_req   = 1'b0;
        words_sent = 0;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_BOX;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // scores before any box use the all-zero box
        send_word(OP_SCORE, score_word(16'h8000), 1'b1);
        // box with tlast set, extreme fields, tied maxima keep the first class
        send_word(OP_BOX, box_word(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF), 1'b1);
        send_word(OP_SCORE, score_word(16'hFFFF), 1'b0);
        send_word(OP_SCORE, score_word(16'hFFFF), 1'b0);
        send_word(OP_SCORE, score_word(16'h0000), 1'b1);
        // all-zero scores stay below threshold
        send_word(OP_BOX, box_word(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000), 1'b0);
        send_word(OP_SCORE, score_word(16'h0000), 1'b0);
        send_word(OP_SCORE, score_word(16'h0000), 1'b1);
        // equal to threshold is dropped, one above passes, held box reused
        send_word(OP_SCORE, score_word(RST_THRESHOLD), 1'b1);
        send_word(OP_SCORE, score_word(RST_THRESHOLD + 16'd1), 1'b1);
        send_word(OP_BOX, box_word(16'd640, 16'd480, 16'd320, 16'hFF00), 1'b0);
        send_word(OP_SCORE, score_word(16'd100), 1'b0);
        send_word(OP_SCORE, score_word(16'd40000), 1'b0);
        send_word(OP_SCORE, score_word(16'd40000), 1'b0);
        send_word(OP_SCORE, score_word(16'd50000), 1'b1);
        send_word(OP_SCORE, score_word(16'd1), 1'b0);
        send_word(OP_SCORE, score_word(16'hFFFF), 1'b1);

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            case (ph)
                0: cfg = '{RST_THRESHOLD, RST_INV_SCALE, RST_INV_SCALE, 0, 0, 0, 0, 1};
                1: cfg = '{0, 65535, 65535, 4095, 4095, 8191, 8191, 1};
                2: cfg = '{0, 0, 0, 0, 0, 0, 0, 0};
                3: cfg = '{65534, $urandom, $urandom, $urandom_range(4095),
                           $urandom_range(4095), $urandom_range(8191),
                           $urandom_range(8191), 0};
                default: cfg = '{$urandom_range(50000), $urandom_range(65535),
                                 $urandom_range(65535), $urandom_range(4095),
                                 $urandom_range(4095), $urandom_range(8191),
                                 $urandom_range(8191), $urandom_range(1)};
            endcase
            if (ph != 0) write_all(cfg);
            calm_run = (ph == 2);
            if (ph == 1 || ph == 5) begin
                random_anchor(256 + $urandom_range(40), 1'b1);
                random_anchor(256 + $urandom_range(40), 1'b0);
            end
            if (ph == 4) begin
                hold_req = 1'b1;
                for (int i = 0; i < 40; i++) begin
                    send_word(OP_BOX, box_word(rand_coord(), rand_coord(), rand_coord(),
                                               rand_coord()), 1'b0);
                    send_word(OP_SCORE, score_word(16'($urandom_range(65535, 60001))), 1'b1);
                end
            end
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end) begin
                if ($urandom_range(9) == 0) begin
                    send_word(1'($urandom),
                              t_anchor_word'(S_DATA_W'({$urandom, $urandom, $urandom})),
                              1'($urandom));
                end else begin
                    random_anchor($urandom_range(3) == 0 ? $urandom_range(20, 1)
                                                          : $urandom_range(6, 1), 1'b0);
                end
            end
        end
        calm_run = 1'b0;
        drain();
        repeat (20) @(posedge i_clk);

        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
